// File: src/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, codes and constants for the integer to radix digits block.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned RADIX_W         = 5;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_INDEX_W     = 2;
  localparam int unsigned FUNC_W          = 2;
  localparam int unsigned COUNT_W         = 6;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned PFX_IDX_W       = 3;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHARS_HIGH = 2'd2;

  // conversion modes
  localparam logic [FUNC_W-1:0] FUNC_SIGNED   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UNSIGNED = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POINTER  = 2'd2;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREFIX,
    ST_DIGIT
  } state_t;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_HEX,
    PFX_NIL
  } pfx_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_prefix;
    logic emit_digit;
  } itrd_cmd_t;

  typedef struct packed {
    logic is_nil;
    logic has_prefix;
    logic prefix_last;
    logic div_last;
    logic quot_zero;
    logic depth_one;
    logic out_free;
  } itrd_sts_t;

  // Prefix text: "-", "0x" or "(nil)"
  function automatic logic [7:0] pfx_char(input pfx_t kind,
                                          input logic [PFX_IDX_W-1:0] idx);
    logic [7:0] ch;
    ch = CH_MINUS;
    unique case (kind)
      PFX_HEX: ch = (idx == 3'd0) ? CH_ZERO : CH_X;
      PFX_NIL: begin
        case (idx)
          3'd0:    ch = CH_LPAR;
          3'd1:    ch = CH_N;
          3'd2:    ch = CH_I;
          3'd3:    ch = CH_L;
          default: ch = CH_RPAR;
        endcase
      end
      default: ch = CH_MINUS;
    endcase
    return ch;
  endfunction

endpackage

// File: src/itrd_ctrl.sv
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: load an item, divide out digits, emit any prefix, then digits.
// ----------------------------------------------------------------------------
module itrd_ctrl import itrd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  itrd_sts_t sts,
  output itrd_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.is_nil) begin
          state_next = ST_PREFIX;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_last && sts.quot_zero) begin
            state_next = sts.has_prefix ? ST_PREFIX : ST_DIGIT;
          end
        end
      end
      ST_PREFIX: begin
        if (sts.out_free) begin
          cmd.emit_prefix = 1'b1;
          if (sts.prefix_last) begin
            state_next = sts.is_nil ? ST_IDLE : ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.depth_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/itrd_dp.sv
// ----------------------------------------------------------------------------
// itrd_dp
// Datapath: config registers, bit-serial radix divider, digit stack and
// output register.
// ----------------------------------------------------------------------------
module itrd_dp import itrd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [31:0]             value,
  input  logic [FUNC_W-1:0]       func,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              char_code,
  output logic [COUNT_W-1:0]      char_count,
  output logic                    last,
  input  itrd_cmd_t               cmd,
  output itrd_sts_t               sts
);

  localparam int unsigned BITCNT_W = $clog2(VALUE_WIDTH);
  localparam int unsigned DEPTH_W  = $clog2(VALUE_WIDTH + 1);

  logic [RADIX_W-1:0]       radix;
  logic [CFG_DATA_W-1:0]    chars_low;
  logic [CFG_DATA_W-1:0]    chars_high;

  logic [VALUE_WIDTH-1:0]   mag;
  logic [DIGIT_W-1:0]       rem;
  logic [BITCNT_W-1:0]      bitcnt;
  logic [DEPTH_W-1:0]       depth;
  logic [DIGIT_W-1:0]       stack [VALUE_WIDTH];
  pfx_t                     kind;
  logic [PFX_IDX_W-1:0]     pfx_idx;
  logic [COUNT_W-1:0]       count;

  logic [RADIX_W-1:0]       base;
  logic [VALUE_WIDTH-1:0]   v_in;
  logic [RADIX_W-1:0]       rem_sh;
  logic                     q_bit;
  logic [DIGIT_W-1:0]       rem_step;
  logic [VALUE_WIDTH-1:0]   mag_step;
  logic [2*CFG_DATA_W-1:0]  table_bits;
  logic [7:0]               digit_byte;
  logic [COUNT_W-1:0]       count_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= RADIX_RESET;
      chars_low  <= '0;
      chars_high <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RADIX:      radix      <= cfg_data[RADIX_W-1:0];
        REG_CHARS_LOW:  chars_low  <= cfg_data;
        REG_CHARS_HIGH: chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  // One restoring-division bit per cycle
  assign v_in     = VALUE_WIDTH'(value);
  assign rem_sh   = {rem, mag[VALUE_WIDTH-1]};
  assign q_bit    = (rem_sh >= base);
  assign rem_step = q_bit ? DIGIT_W'(rem_sh - base) : rem_sh[DIGIT_W-1:0];
  assign mag_step = {mag[VALUE_WIDTH-2:0], q_bit};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem    <= '0;
      bitcnt <= '0;
      if (func == FUNC_SIGNED && v_in[VALUE_WIDTH-1]) begin
        kind <= PFX_MINUS;
        mag  <= '0 - v_in;
      end else if (func == FUNC_POINTER) begin
        kind <= (v_in == '0) ? PFX_NIL : PFX_HEX;
        mag  <= v_in;
      end else begin
        kind <= PFX_NONE;
        mag  <= v_in;
      end
    end else if (cmd.div_step) begin
      mag <= mag_step;
      if (sts.div_last) begin
        rem    <= '0;
        bitcnt <= '0;
      end else begin
        rem    <= rem_step;
        bitcnt <= bitcnt + BITCNT_W'(1);
      end
    end
  end

  // Digit stack: push at entry 0 on each finished division, pop from entry 0
  always_ff @(posedge clk) begin
    if (cmd.div_step && sts.div_last) begin
      stack[0] <= rem_step;
      for (int i = 1; i < VALUE_WIDTH; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (cmd.emit_digit) begin
      for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.div_step && sts.div_last) begin
      depth <= depth + DEPTH_W'(1);
    end else if (cmd.emit_digit) begin
      depth <= depth - DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pfx_idx <= '0;
      count   <= '0;
    end else begin
      if (cmd.emit_prefix) begin
        pfx_idx <= pfx_idx + PFX_IDX_W'(1);
      end
      if (cmd.emit_prefix || cmd.emit_digit) begin
        count <= count_next;
      end
    end
  end

  assign table_bits = {chars_high, chars_low};
  assign digit_byte = table_bits[{stack[0], 3'b000} +: 8];
  assign count_next = count + COUNT_W'(1);

  // Output register: load on emit, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_prefix || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_prefix) begin
      char_code  <= pfx_char(kind, pfx_idx);
      char_count <= count_next;
      last       <= sts.is_nil && sts.prefix_last;
    end else if (cmd.emit_digit) begin
      char_code  <= digit_byte;
      char_count <= count_next;
      last       <= sts.depth_one;
    end
  end

  always_comb begin
    sts.is_nil      = (kind == PFX_NIL);
    sts.has_prefix  = (kind != PFX_NONE);
    sts.prefix_last = (kind == PFX_MINUS && pfx_idx == 3'd0)
                   || (kind == PFX_HEX   && pfx_idx == 3'd1)
                   || (kind == PFX_NIL   && pfx_idx == 3'd4);
    sts.div_last    = (bitcnt == BITCNT_W'(VALUE_WIDTH - 1));
    sts.quot_zero   = (mag_step == '0);
    sts.depth_one   = (depth == DEPTH_W'(1));
    sts.out_free    = !out_valid || !out_stall;
  end

endmodule

// File: src/integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Integer to radix digit characters, with sign, pointer prefix and nil text.
// ----------------------------------------------------------------------------
// One item at a time. After the input transfer, each digit runs through the
// one-bit-per-cycle radix divider, and then every character passes through
// the output register, where output stalls can hold it. The nil text skips
// the divider but still passes through the divide state.
// The next item is taken as soon as the last character has been loaded into
// the output register.
module integer_to_radix_digits import itrd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            value,
  input  logic [FUNC_W-1:0]      func,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             char_code,
  output logic [COUNT_W-1:0]     char_count,
  output logic                   last
);

  itrd_cmd_t cmd;
  itrd_sts_t sts;

  itrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itrd_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .value      (value),
    .func       (func),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_code  (char_code),
    .char_count (char_count),
    .last       (last),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_radix_digits: drives integers in every
// mode and many radixes, predicts the character stream, compares per transfer.
// ----------------------------------------------------------------------------
module tb;
  import itrd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned GAP_PERCENT    = 18;

  // mode and register codes that the package leaves unnamed
  localparam logic [FUNC_W-1:0]      FUNC_SPARE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE  = 2'd3;

  // digit tables
  localparam logic [CFG_DATA_W-1:0] HEX_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] HEX_HIGH = 64'h6665_6463_6261_3938;

  typedef struct {
    logic [7:0]         code;
    logic [COUNT_W-1:0] count;
    logic               fin;
  } out_char_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [31:0]            value = '0;
  logic [FUNC_W-1:0]      func = FUNC_SIGNED;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             char_code;
  logic [COUNT_W-1:0]     char_count;
  logic                   last;

  // predictor copy of the registers
  logic [RADIX_W-1:0]    radix_cfg = RADIX_RESET;
  logic [CFG_DATA_W-1:0] glyph_lo = '0;
  logic [CFG_DATA_W-1:0] glyph_hi = '0;

  out_char_t   expected_chars[$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  logic        gaps_on = 1'b1;

  integer_to_radix_digits dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .func       (func),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_code  (char_code),
    .char_count (char_count),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Build the character stream for one integer and queue it
  function automatic void predict_text(input logic [31:0] v, input logic [FUNC_W-1:0] f);
    logic [7:0]   text[$];
    logic [7:0]   digits[$];
    logic [127:0] glyphs;
    logic [32:0]  mag;
    int unsigned  base;
    int unsigned  d;
    out_char_t    c;
    glyphs = {glyph_hi, glyph_lo};
    mag = {1'b0, v};
    if (radix_cfg < RADIX_MIN) begin
      base = 2;
    end else if (radix_cfg > RADIX_MAX) begin
      base = 16;
    end else begin
      base = 32'(radix_cfg);
    end
    if (f == FUNC_POINTER && v == 32'd0) begin
      text.push_back(CH_LPAR);
      text.push_back(CH_N);
      text.push_back(CH_I);
      text.push_back(CH_L);
      text.push_back(CH_RPAR);
    end else begin
      if (f == FUNC_SIGNED && v[31]) begin
        text.push_back(CH_MINUS);
        // the most negative value keeps its full magnitude in 33 bits
        mag = {1'b0, ~v + 32'd1};
      end
      if (f == FUNC_POINTER) begin
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
      end
      do begin
        d = 32'(mag % base);
        digits.push_front(glyphs[d*8 +: 8]);
        mag = mag / base;
      end while (mag != 0);
      foreach (digits[i]) text.push_back(digits[i]);
    end
    foreach (text[i]) begin
      c.code = text[i];
      c.count = COUNT_W'(i + 1);
      c.fin = (i == text.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom_range(20);
      1: v = 32'h8000_0000 + $urandom_range(3);
      2: v = 32'hFFFF_FFFF - $urandom_range(3);
      3: v = 32'd1 << $urandom_range(31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Send one item; valid stays high after the transfer until the caller's
  // next step decides otherwise
  task automatic send_item(input logic [31:0] v, input logic [FUNC_W-1:0] f);
    while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    func <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_text(v, f);
  endtask

  // Hold off until every expected character has arrived and the block is idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_RADIX:      radix_cfg = data[RADIX_W-1:0];
      REG_CHARS_LOW:  glyph_lo = data;
      REG_CHARS_HIGH: glyph_hi = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Upper data bits are junk; only the low radix bits count
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    logic [CFG_DATA_W-1:0] data;
    data = {$urandom, $urandom};
    data[RADIX_W-1:0] = r;
    write_reg(REG_RADIX, data);
  endtask

  task automatic test_reset_defaults();
    // decimal radix and an all-zero table straight out of reset
    send_item(32'd123, FUNC_SIGNED);
    send_item(32'hFFFF_FF85, FUNC_POINTER);
    wait_idle();
  endtask

  task automatic test_directed();
    write_reg(REG_CHARS_LOW, HEX_LOW);
    write_reg(REG_CHARS_HIGH, HEX_HIGH);
    write_reg(REG_SPARE, {$urandom, $urandom});
    set_radix(5'd10);
    send_item(32'd0, FUNC_SIGNED);
    send_item(32'd0, FUNC_UNSIGNED);
    send_item(32'd0, FUNC_POINTER);
    send_item(32'hFFFF_FFFF, FUNC_SIGNED);
    send_item(32'h8000_0000, FUNC_SIGNED);
    send_item(32'h7FFF_FFFF, FUNC_SIGNED);
    send_item(32'hFFFF_FFFF, FUNC_UNSIGNED);
    send_item(32'h8000_0000, FUNC_SPARE);
    send_item(32'hDEAD_BEEF, FUNC_POINTER);
    wait_idle();
    set_radix(RADIX_MAX);
    send_item(32'hFFFF_FFFF, FUNC_POINTER);
    send_item(32'h8000_0000, FUNC_SIGNED);
    wait_idle();
    // longest streams: 32 binary digits, bare, after a sign and after a prefix
    set_radix(RADIX_MIN);
    send_item(32'hFFFF_FFFF, FUNC_UNSIGNED);
    send_item(32'h8000_0000, FUNC_SIGNED);
    send_item(32'h8000_0001, FUNC_POINTER);
    wait_idle();
    // out-of-range radix clamps to 2 below and 16 above
    set_radix(5'd0);
    send_item(32'd5, FUNC_UNSIGNED);
    wait_idle();
    set_radix(5'd1);
    send_item(32'd6, FUNC_SIGNED);
    wait_idle();
    set_radix(5'd17);
    send_item(32'h0001_2345, FUNC_UNSIGNED);
    wait_idle();
    set_radix(5'd31);
    send_item(32'hFEDC_BA98, FUNC_POINTER);
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [RADIX_W-1:0] r;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: r = RADIX_MIN;
        1: r = RADIX_MAX;
        2: r = 5'd10;
        3: r = RADIX_W'($urandom_range(3, 15));
        4: r = $urandom_range(1) ? 5'd0 : 5'd31;
        default: r = RADIX_W'($urandom_range(31));
      endcase
      set_radix(r);
      case (p)
        1: begin
          write_reg(REG_CHARS_LOW, '1);
          write_reg(REG_CHARS_HIGH, '1);
        end
        2: begin
          write_reg(REG_CHARS_LOW, HEX_LOW);
          write_reg(REG_CHARS_HIGH, HEX_HIGH);
        end
        default: begin
          write_reg(REG_CHARS_LOW, {$urandom, $urandom});
          write_reg(REG_CHARS_HIGH, {$urandom, $urandom});
        end
      endcase
      for (int i = 0; i < 12; i++) send_item(rand_value(), FUNC_W'($urandom_range(3)));
      wait_idle();
    end
  endtask

  task automatic test_burst();
    gaps_on = 1'b0;
    set_radix(RADIX_W'($urandom_range(2, 16)));
    for (int i = 0; i < 20; i++) send_item(rand_value(), FUNC_W'($urandom_range(3)));
    wait_idle();
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
  end

  always @(posedge clk) begin : check_chars
    out_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: char_code %0h char_count %0d last %0b",
               char_code, char_count, last);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (char_code !== want.code) begin
          $error("char_code: expected %0h, got %0h", want.code, char_code);
          errors++;
        end
        if (char_count !== want.count) begin
          $error("char_count: expected %0d, got %0d", want.count, char_count);
          errors++;
        end
        if (last !== want.fin) begin
          $error("last: expected %0b, got %0b", want.fin, last);
          errors++;
        end
      end
    end
  end

  // Count cycles with no transfer at all
  always @(posedge clk) begin : watchdog
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_phases();
    test_burst();
    wait_idle();
    if (expected_chars.size() != 0) begin
      $error("%0d characters never arrived", expected_chars.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
